FILE: hdl/cursor_array_list_unit_macros.svh
// Assertion macros for the cursor array list unit.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef CURSOR_ARRAY_LIST_UNIT_MACROS_SVH
`define CURSOR_ARRAY_LIST_UNIT_MACROS_SVH

`ifndef SYNTH
// Property holds at every clock edge out of reset
`define CAL_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);
// When pre holds, post holds at the next edge
`define CAL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CAL_ASSERT(lbl, expr, msg)
`define CAL_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: hdl/cal_pkg.sv
package cal_pkg;

  // Storage geometry
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  // Internal widths: count and cursor hold 0..DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Port field widths
  localparam int KIND_W = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  // Width wide enough for compares against port fields
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 4'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 4'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_FRONT  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_BACK   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PREV   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 4'd8;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_ELEM = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd3;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_APP,
    OP_REM
  } cal_op_e;

  // Decoded operation, broadcast to the cells and used by the control
  typedef struct packed {
    cal_op_e              op;
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     cursor;
    logic [CNT_W-1:0]     count;
    logic [STAT_W-1:0]    status;
    logic [CNT_W-1:0]     count_nxt;
    logic [CNT_W-1:0]     cursor_nxt;
  } cal_dec_t;

endpackage

FILE: hdl/cal_ctrl.sv
module cal_ctrl import cal_pkg::*; (
  input  logic [KIND_W-1:0] kind_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [CNT_W-1:0]  cursor_i,
  input  logic [CAP_W-1:0]  capacity_i,
  output cal_dec_t          dec_o
);

  logic [CMP_W-1:0] eff_cap;
  logic             full;

  // Effective capacity is the smaller of the register and the depth
  assign eff_cap = (CMP_W'(capacity_i) < CMP_W'(DEPTH)) ? CMP_W'(capacity_i)
                                                        : CMP_W'(DEPTH);
  assign full    = (CMP_W'(count_i) >= eff_cap);

  // Decode; a failed operation leaves op at hold and the state unchanged
  always_comb begin
    dec_o            = '0;
    dec_o.op         = OP_HOLD;
    dec_o.word       = WORD_BITS'(value_i);
    dec_o.cursor     = cursor_i;
    dec_o.count      = count_i;
    dec_o.status     = ST_OK;
    dec_o.count_nxt  = count_i;
    dec_o.cursor_nxt = cursor_i;
    unique case (kind_i)
      KIND_INSERT, KIND_APPEND: begin
        if (full) begin
          dec_o.status = ST_FULL;
        end else begin
          dec_o.op        = (kind_i == KIND_INSERT) ? OP_INS : OP_APP;
          dec_o.count_nxt = count_i + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (cursor_i >= count_i) begin
          dec_o.status = ST_NO_ELEM;
        end else begin
          dec_o.op        = OP_REM;
          dec_o.count_nxt = count_i - 1'b1;
        end
      end
      KIND_FRONT: dec_o.cursor_nxt = '0;
      KIND_BACK:  dec_o.cursor_nxt = count_i;
      KIND_PREV: begin
        if (cursor_i != '0) dec_o.cursor_nxt = cursor_i - 1'b1;
      end
      KIND_NEXT: begin
        if (cursor_i < count_i) dec_o.cursor_nxt = cursor_i + 1'b1;
      end
      KIND_MOVE: begin
        if (CMP_W'(position_i) > CMP_W'(count_i)) begin
          dec_o.status = ST_BAD_POS;
        end else begin
          dec_o.cursor_nxt = CNT_W'(position_i);
        end
      end
      KIND_CLEAR: begin
        dec_o.count_nxt  = '0;
        dec_o.cursor_nxt = '0;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/cal_cell.sv
module cal_cell import cal_pkg::*; (
  input  logic                 clk_i,
  input  cal_dec_t             ctl_i,
  input  logic [CNT_W-1:0]     idx_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] data_o
);

  logic [WORD_BITS-1:0] data_d, data_q;

  // Shift up on insert, down on remove, load on append
  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      OP_INS: begin
        if (idx_i > ctl_i.cursor) begin
          data_d = left_i;
        end else if (idx_i == ctl_i.cursor) begin
          data_d = ctl_i.word;
        end
      end
      OP_APP: begin
        if (idx_i == ctl_i.count) data_d = ctl_i.word;
      end
      OP_REM: begin
        if (idx_i >= ctl_i.cursor) data_d = right_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: hdl/cursor_array_list_unit.sv
// Cursor array list unit: a row of word cells with a cursor.
// Result path: an accepted item sets the pending flag, and the result register
// loads from it once the output is free; out_valid_o is registered.
// Throughput: one item per cycle while results drain; a held result blocks the
// input. Cells shift on acceptance; the cursor word is read as the result loads.
// Reset: length and cursor clear, capacity returns to 16, no result pending.
`include "cursor_array_list_unit_macros.svh"

module cursor_array_list_unit import cal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Item channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [POS_W-1:0]  position_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [VAL_W-1:0]  removed_value_o,
  output logic [LEN_W-1:0]  list_length_o,
  output logic [LEN_W-1:0]  cursor_position_o,
  output logic [VAL_W-1:0]  cursor_value_o,
  output logic              cursor_valid_o,
  // Capacity write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i
);

  logic [CAP_W-1:0]     capacity_q;
  logic [CNT_W-1:0]     count_q, cursor_q;
  logic                 busy_q, out_valid_q;
  logic [STAT_W-1:0]    pend_status_q;
  logic [VAL_W-1:0]     pend_removed_q;
  logic [STAT_W-1:0]    out_status_q;
  logic [VAL_W-1:0]     out_removed_q, out_cval_q;
  logic [LEN_W-1:0]     out_len_q, out_cur_q;
  logic                 out_cvalid_q;

  cal_dec_t             dec, cell_ctl;
  logic                 accept, load;
  logic                 cur_valid;
  logic [WORD_BITS-1:0] cells [DEPTH];
  logic [WORD_BITS-1:0] rd_word;

  // Handshakes
  assign load        = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !busy_q || load;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Operation decode
  cal_ctrl u_ctrl (
    .kind_i     (kind_i),
    .value_i    (value_i),
    .position_i (position_i),
    .count_i    (count_q),
    .cursor_i   (cursor_q),
    .capacity_i (capacity_q),
    .dec_o      (dec)
  );

  // Cells only move on an accepted beat
  always_comb begin
    cell_ctl = dec;
    if (!accept) cell_ctl.op = OP_HOLD;
  end

  // Cell row; the top cell pulls zero on remove
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cells[g+1];
    end
    cal_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .idx_i   (CNT_W'(g)),
      .left_i  (left),
      .right_i (right),
      .data_o  (cells[g])
    );
  end

  // Word under the cursor: pre-op word for remove, post-op word for results
  assign cur_valid = (cursor_q < count_q);
  assign rd_word   = cur_valid ? cells[cursor_q[IDX_W-1:0]] : '0;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  // List control state and pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q  <= dec.count_nxt;
        cursor_q <= dec.cursor_nxt;
        busy_q   <= 1'b1;
      end else if (load) begin
        busy_q   <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q  <= dec.status;
      pend_removed_q <= (dec.op == OP_REM) ? VAL_W'(rd_word) : '0;
    end
    if (load) begin
      out_status_q  <= pend_status_q;
      out_removed_q <= pend_removed_q;
      out_len_q     <= LEN_W'(count_q);
      out_cur_q     <= LEN_W'(cursor_q);
      out_cval_q    <= VAL_W'(rd_word);
      out_cvalid_q  <= cur_valid;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign removed_value_o   = out_removed_q;
  assign list_length_o     = out_len_q;
  assign cursor_position_o = out_cur_q;
  assign cursor_value_o    = out_cval_q;
  assign cursor_valid_o    = out_cvalid_q;

  // Checks
  `CAL_ASSERT(a_cursor_in_list, cursor_q <= count_q, "cursor beyond list length")
  `CAL_ASSERT(a_count_in_depth, count_q <= CNT_W'(DEPTH), "list length beyond depth")
  `CAL_ASSERT_NEXT(a_accept_pends, accept, busy_q, "accepted beat left no pending result")
  `CAL_ASSERT_NEXT(a_count_holds, !accept, $stable(count_q), "length moved without a beat")

endmodule
